// File: rtl/egvo_pkg.sv
// Shared constants and types for the energy-gated voice onset block.
`default_nettype none

package egvo_pkg;

    localparam int SAMPLE_W              = 16;
    localparam int MAG_W                 = SAMPLE_W + 1;
    localparam int RMS_W                 = 16;
    localparam int VAL_W                 = 2 * RMS_W;
    localparam int UNIT_W                = RMS_W + 3;
    localparam int THR_W                 = 16;
    localparam int VERDICT_W             = 2;
    localparam int ADDR_W                = 3;
    localparam int DATA_W                = 32;
    localparam int MAX_FRAME_SAMPLES_DEF = 1024;

    localparam logic [THR_W-1:0]     ONSET_RESET     = 16'd240;
    localparam logic [VERDICT_W-1:0] VERDICT_SILENCE = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SPEECH  = 2'd2;
    localparam logic                 CMD_RESET       = 1'b1;
    localparam logic [ADDR_W-1:0]    ADDR_ONSET      = 3'd0;

    typedef struct packed {
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] diff;
        logic              ge;
    } unit_rsp_t;

endpackage

`default_nettype wire

// File: rtl/egvo_unit.sv
// Shared compare-and-subtract unit used by the divider and the square root.
`default_nettype none

module egvo_unit (
    input  wire egvo_pkg::unit_req_t req,
    output egvo_pkg::unit_rsp_t      rsp
);
    import egvo_pkg::*;

    logic [UNIT_W:0] wide;

    assign wide     = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.diff = wide[UNIT_W-1:0];
    assign rsp.ge   = ~wide[UNIT_W];

endmodule

`default_nettype wire

// File: rtl/egvo_seq.sv
// Sequencer: energy accumulation, iterative divide and square root, onset gating.
`default_nettype none

module egvo_seq #(
    parameter int MAX_FRAME_SAMPLES = egvo_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [egvo_pkg::THR_W-1:0]     onset_threshold,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic signed [egvo_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                           frame_last,
    input  wire logic [egvo_pkg::VERDICT_W-1:0] vad_verdict,
    input  wire logic                           frame_failed,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [egvo_pkg::RMS_W-1:0]          rms_level,
    output logic                                speaking,
    output logic                                onset,
    output logic                                speech_end
);
    import egvo_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W  = 2 * (MAG_W - 1) + CNT_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_FRAME_SAMPLES);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(RMS_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_DIV,
        S_SQRT,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  talk_reg, talk_next;
    logic                  disc_reg, disc_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  add_en_reg, add_en_next;
    logic                  last_reg, last_next;
    logic                  fail_reg, fail_next;
    logic [VERDICT_W-1:0]  verdict_reg, verdict_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [SUM_W-1:0]      div_reg, div_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [UNIT_W-1:0]     srem_reg, srem_next;
    logic [RMS_W-1:0]      root_reg, root_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]      rms_out_reg, rms_out_next;
    logic                  speaking_reg, speaking_next;
    logic                  onset_reg, onset_next;
    logic                  end_reg, end_next;

    unit_req_t             req;
    unit_rsp_t             rsp;
    logic [CNT_W:0]        div_shift;
    logic [UNIT_W-1:0]     sq_shift;
    logic [SUM_W-1:0]      sum_add;
    logic [SUM_W-1:0]      quot;
    logic                  talk_new;

    egvo_unit u_unit (
        .req (req),
        .rsp (rsp)
    );

    assign div_shift = {rem_reg, div_reg[SUM_W-1]};
    assign sq_shift  = {srem_reg[UNIT_W-3:0], val_reg[VAL_W-1 -: 2]};
    assign sum_add   = sum_reg + (add_en_reg ? SUM_W'(prod_reg) : {SUM_W{1'b0}});
    assign quot      = {div_reg[SUM_W-2:0], rsp.ge};

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            req.a = UNIT_W'(div_shift);
            req.b = UNIT_W'(n_reg);
        end
        else
        begin
            req.a = sq_shift;
            req.b = UNIT_W'({root_reg, 2'b01});
        end
    end

    always_comb
    begin
        if (verdict_reg == VERDICT_SPEECH)
        begin
            talk_new = talk_reg || (root_reg >= onset_threshold);
        end
        else if (verdict_reg == VERDICT_SILENCE)
        begin
            talk_new = 1'b0;
        end
        else
        begin
            talk_new = talk_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        talk_next      = talk_reg;
        disc_next      = disc_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        add_en_next    = add_en_reg;
        last_next      = last_reg;
        fail_next      = fail_reg;
        verdict_next   = verdict_reg;
        n_next         = n_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        val_next       = val_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        rms_out_next   = rms_out_reg;
        speaking_next  = speaking_reg;
        onset_next     = onset_reg;
        end_next       = end_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_RESET)
                    begin
                        talk_next = 1'b0;
                        disc_next = 1'b1;
                        sum_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        mag_next     = sample[SAMPLE_W-1]
                                     ? (MAG_W'(0) - {sample[SAMPLE_W-1], sample})
                                     : {1'b0, sample};
                        add_en_next  = cnt_reg < MAX_CNT;
                        if (cnt_reg < MAX_CNT)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        last_next    = frame_last;
                        fail_next    = frame_failed;
                        verdict_next = vad_verdict;
                        state_next   = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                prod_next  = mag_reg * mag_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_IDLE;
                if (!last_reg)
                begin
                    sum_next = sum_add;
                end
                else
                begin
                    sum_next = '0;
                    cnt_next = '0;
                    if (disc_reg)
                    begin
                        disc_next = 1'b0;
                        talk_next = 1'b0;
                    end
                    else if (!fail_reg)
                    begin
                        div_next   = sum_add;
                        n_next     = cnt_reg;
                        rem_next   = '0;
                        step_next  = DIV_LAST;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = rsp.ge ? rsp.diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                div_next  = quot;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    val_next   = VAL_W'(quot);
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = SQRT_LAST;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                srem_next = rsp.ge ? rsp.diff : sq_shift;
                root_next = {root_reg[RMS_W-2:0], rsp.ge};
                val_next  = {val_reg[VAL_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    talk_next      = talk_new;
                    out_valid_next = 1'b1;
                    rms_out_next   = root_reg;
                    speaking_next  = talk_new;
                    onset_next     = talk_new && !talk_reg;
                    end_next       = !talk_new && talk_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            talk_reg      <= 1'b0;
            disc_reg      <= 1'b0;
            mag_reg       <= '0;
            prod_reg      <= '0;
            add_en_reg    <= 1'b0;
            last_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            verdict_reg   <= '0;
            n_reg         <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            val_reg       <= '0;
            srem_reg      <= '0;
            root_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            rms_out_reg   <= '0;
            speaking_reg  <= 1'b0;
            onset_reg     <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            talk_reg      <= talk_next;
            disc_reg      <= disc_next;
            mag_reg       <= mag_next;
            prod_reg      <= prod_next;
            add_en_reg    <= add_en_next;
            last_reg      <= last_next;
            fail_reg      <= fail_next;
            verdict_reg   <= verdict_next;
            n_reg         <= n_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            val_reg       <= val_next;
            srem_reg      <= srem_next;
            root_reg      <= root_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            rms_out_reg   <= rms_out_next;
            speaking_reg  <= speaking_next;
            onset_reg     <= onset_next;
            end_reg       <= end_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign rms_level  = rms_out_reg;
    assign speaking   = speaking_reg;
    assign onset      = onset_reg;
    assign speech_end = end_reg;

endmodule

`default_nettype wire

// File: rtl/energy_gated_vad_onset_top.sv
// Top level of the energy-gated voice onset block: register port and sequencer.
`default_nettype none

// Frame-energy gate on a voice-activity verdict. Samples are transferred one
// at a time; each non-final sample passes through capture, square and
// accumulate. The last sample of a frame that produces a result also runs a
// restoring divide of the square sum by the sample count, 32 + clog2(MAX+1)
// steps (43 at the default), then a 16-step square root, both on one shared
// compare-subtract unit, and then loads the output register, which waits
// while the output is stalled. A reset command is taken in the idle state;
// discarded and failed frames end after the accumulate step. The onset
// threshold sits at byte address 0 and resets to 240.
module energy_gated_vad_onset_top #(
    parameter int MAX_FRAME_SAMPLES = egvo_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [egvo_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [egvo_pkg::DATA_W-1:0]    pwdata,
    output logic [egvo_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic signed [egvo_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                           frame_last,
    input  wire logic [egvo_pkg::VERDICT_W-1:0] vad_verdict,
    input  wire logic                           frame_failed,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [egvo_pkg::RMS_W-1:0]          rms_level,
    output logic                                speaking,
    output logic                                onset,
    output logic                                speech_end
);
    import egvo_pkg::*;

    logic [THR_W-1:0] thr_reg, thr_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        thr_next = thr_reg;
        if (wr_en && (paddr == ADDR_ONSET))
        begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ONSET_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata = (paddr == ADDR_ONSET) ? DATA_W'(thr_reg) : {DATA_W{1'b0}};

    egvo_seq #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .onset_threshold (thr_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .sample          (sample),
        .frame_last      (frame_last),
        .vad_verdict     (vad_verdict),
        .frame_failed    (frame_failed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rms_level       (rms_level),
        .speaking        (speaking),
        .onset           (onset),
        .speech_end      (speech_end)
    );

`ifndef ASSERT_OFF
    a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(onset && speech_end))
        else $error("onset and speech_end both set");

    a_edges_match_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (onset || speech_end)) |-> (speaking == onset))
        else $error("transition flag disagrees with speaking");

    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rms_level <= 16'd32768))
        else $error("rms_level out of range");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rms_level)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: verif/tb_energy_gated_vad_onset_top.sv
// Self-checking testbench for energy_gated_vad_onset_top: frame RMS and onset scoreboard, APB setup.
`default_nettype none

module tb_energy_gated_vad_onset_top;
    timeunit 1ns;
    timeprecision 1ps;

    import egvo_pkg::*;

    localparam int MAX_SAMPLES    = MAX_FRAME_SAMPLES_DEF;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ROUND_ITEMS    = 150;
    localparam int ROUNDS         = 5;

    localparam logic                 CMD_SAMPLE     = 1'b0;
    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SPARE  = 2'd3;
    localparam logic [ADDR_W-1:0]    ADDR_UNUSED    = 3'd4;
    localparam logic [THR_W-1:0]     THR_TOP        = 16'd32768;

    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             speaking;
        logic             onset;
        logic             speech_end;
    } frame_result_t;

    class onset_scoreboard;
        logic [THR_W-1:0]  onset_thr;
        longint unsigned   energy;
        int unsigned       taken;
        bit                talking;
        bit                skip_next;
        frame_result_t     pending[$];
        int                errors;
        int                results;
        int                onsets;
        int                ends;
        int                silent_frames;

        function new();
            onset_thr     = ONSET_RESET;
            energy        = 0;
            taken         = 0;
            talking       = 1'b0;
            skip_next     = 1'b0;
            errors        = 0;
            results       = 0;
            onsets        = 0;
            ends          = 0;
            silent_frames = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            int              b;
            r = 0;
            for (b = 16; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function void take_item(logic cmd, logic signed [SAMPLE_W-1:0] smp, logic last,
                                logic [VERDICT_W-1:0] verdict, logic failed);
            longint          mag;
            longint unsigned rms;
            bit              was;
            frame_result_t   res;
            if (cmd == CMD_RESET)
            begin
                talking   = 1'b0;
                skip_next = 1'b1;
                energy    = 0;
                taken     = 0;
                return;
            end
            if (taken < MAX_SAMPLES)
            begin
                mag = smp;
                if (mag < 0)
                    mag = -mag;
                energy += mag * mag;
                taken++;
            end
            if (!last)
                return;
            rms    = (taken != 0) ? floor_root(energy / taken) : 0;
            energy = 0;
            taken  = 0;
            if (skip_next)
            begin
                skip_next = 1'b0;
                talking   = 1'b0;
                silent_frames++;
                return;
            end
            if (failed)
            begin
                silent_frames++;
                return;
            end
            was = talking;
            if (verdict == VERDICT_SPEECH)
            begin
                if (talking || rms >= onset_thr)
                    talking = 1'b1;
            end
            else if (verdict == VERDICT_SILENCE)
                talking = 1'b0;
            res.rms        = RMS_W'(rms);
            res.speaking   = talking;
            res.onset      = talking && !was;
            res.speech_end = !talking && was;
            if (res.onset)
                onsets++;
            if (res.speech_end)
                ends++;
            pending = {pending, res};
        endfunction

        function void match_frame(frame_result_t got);
            frame_result_t want;
            results++;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected result rms=%0d speaking=%0b onset=%0b end=%0b",
                               got.rms, got.speaking, got.onset, got.speech_end));
                return;
            end
            want = pending.pop_front();
            if (got.rms !== want.rms || got.speaking !== want.speaking ||
                got.onset !== want.onset || got.speech_end !== want.speech_end)
                flag($sformatf({"result %0d: expected rms=%0d speaking=%0b onset=%0b end=%0b,",
                                " got rms=%0d speaking=%0b onset=%0b end=%0b"},
                               results, want.rms, want.speaking, want.onset, want.speech_end,
                               got.rms, got.speaking, got.onset, got.speech_end));
        endfunction
    endclass

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [ADDR_W-1:0]           paddr        = '0;
    logic [DATA_W-1:0]           pwdata       = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        command      = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        frame_last   = 1'b0;
    logic [VERDICT_W-1:0]        vad_verdict  = '0;
    logic                        frame_failed = 1'b0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [RMS_W-1:0]            rms_level;
    logic                        speaking;
    logic                        onset;
    logic                        speech_end;

    onset_scoreboard sb;
    int  sent        = 0;
    int  thr_writes  = 0;
    int  gap_pct     = 20;
    int  out_run     = 0;
    int  quiet_cycles = 0;
    bit  calm_tail   = 1'b0;

    energy_gated_vad_onset_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .sample       (sample),
        .frame_last   (frame_last),
        .vad_verdict  (vad_verdict),
        .frame_failed (frame_failed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rms_level    (rms_level),
        .speaking     (speaking),
        .onset        (onset),
        .speech_end   (speech_end)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm_tail)
        begin
            out_stall <= 1'b0;
            out_run   <= 0;
        end
        else if (out_run > 0)
            out_run <= out_run - 1;
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            out_run   <= $urandom_range(1, 18) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            out_run   <= $urandom_range(1, 40) - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
            sb.match_frame({rms_level, speaking, onset, speech_end});
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_threshold();
        logic [DATA_W-1:0] rd;
        apb_read(ADDR_ONSET, rd);
        if (rd !== DATA_W'(sb.onset_thr))
            sb.flag($sformatf("onset_threshold readback: expected %0d, got %0d",
                              sb.onset_thr, rd));
    endtask

    task automatic program_threshold(input logic [THR_W-1:0] value);
        apb_write(ADDR_ONSET, DATA_W'(value));
        sb.onset_thr = value;
        thr_writes++;
        check_threshold();
    endtask

    task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                             input logic last, input logic [VERDICT_W-1:0] verdict,
                             input logic failed);
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample       <= smp;
        frame_last   <= last;
        vad_verdict  <= verdict;
        frame_failed <= failed;
        do @(posedge clk); while (in_stall);
        sb.take_item(cmd, smp, last, verdict, failed);
        sent++;
    endtask

    // hold off until every pending frame result has been transferred
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int amp);
        if (amp >= 32768)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return THR_TOP;
            2:       return THR_W'($urandom_range(0, 40));
            3:       return THR_W'($urandom_range(100, 3000));
            default: return THR_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic random_frame();
        int len;
        int amp;
        int reset_at;
        int i;
        int r;
        logic [VERDICT_W-1:0] verdict;
        if ($urandom_range(0, 3) == 0)
            gap_pct = (gap_pct == 0) ? 30 : 0;
        r = $urandom_range(0, 99);
        len = (r < 65) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 24)
                                                         : $urandom_range(25, 160);
        case ($urandom_range(0, 5))
            0:       amp = 0;
            1:       amp = 12;
            2:       amp = 200;
            3:       amp = 1500;
            4:       amp = 9000;
            default: amp = 32768;
        endcase
        reset_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
        r = $urandom_range(0, 99);
        verdict = (r < 45) ? VERDICT_SPEECH : (r < 80) ? VERDICT_SILENCE :
                  (r < 90) ? VERDICT_NONE : VERDICT_SPARE;
        for (i = 0; i < len; i++)
        begin
            if (i == reset_at)
                send_item(CMD_RESET, SAMPLE_W'($urandom), 1'($urandom), 2'($urandom),
                          1'($urandom));
            if (i == len - 1)
                send_item(CMD_SAMPLE, pick_sample(amp), 1'b1, verdict,
                          $urandom_range(0, 9) == 0);
            else
                send_item(CMD_SAMPLE, pick_sample(amp), 1'b0, 2'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        int round;
        int target;
        bit held;
        sb   = new();
        held = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_threshold();

        // reset threshold: loud onset, none/spare verdicts, silence, threshold edge
        send_item(CMD_SAMPLE, -16'sd32768, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd32767, 1'b1, VERDICT_NONE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd0, 1'b1, VERDICT_SPARE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd5, 1'b1, VERDICT_SILENCE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd239, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, -16'sd240, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd300, 1'b0, VERDICT_SPEECH, 1'b1);
        send_item(CMD_SAMPLE, -16'sd300, 1'b1, VERDICT_SILENCE, 1'b1);
        send_item(CMD_SAMPLE, 16'sd3, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd1000, 1'b0, VERDICT_SILENCE, 1'b0);
        send_item(CMD_RESET, -16'sd1, 1'b1, VERDICT_SPEECH, 1'b1);
        send_item(CMD_SAMPLE, 16'sd1000, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd1000, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_RESET, 16'sd0, 1'b0, VERDICT_NONE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd50, 1'b1, VERDICT_SILENCE, 1'b1);
        send_item(CMD_SAMPLE, 16'sd7, 1'b1, VERDICT_SILENCE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd3, 1'b0, VERDICT_NONE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd4, 1'b0, VERDICT_NONE, 1'b0);
        send_item(CMD_SAMPLE, -16'sd5, 1'b1, VERDICT_SPEECH, 1'b0);

        // top threshold
        settle();
        program_threshold(THR_TOP);
        send_item(CMD_SAMPLE, -16'sd32768, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd32767, 1'b1, VERDICT_SILENCE, 1'b0);
        send_item(CMD_SAMPLE, 16'sd32767, 1'b1, VERDICT_SPEECH, 1'b0);

        // zero threshold, unused address must leave it alone
        settle();
        program_threshold('0);
        send_item(CMD_SAMPLE, 16'sd0, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd0, 1'b1, VERDICT_SILENCE, 1'b0);
        settle();
        apb_write(ADDR_UNUSED, 32'h0000_1234);
        check_threshold();
        send_item(CMD_SAMPLE, 16'sd0, 1'b1, VERDICT_SPEECH, 1'b0);
        send_item(CMD_SAMPLE, 16'sd0, 1'b1, VERDICT_SPARE, 1'b0);

        for (round = 0; round < ROUNDS; round++)
        begin
            settle();
            calm_tail = (round == ROUNDS - 1);
            program_threshold(pick_threshold());
            target = sent + ROUND_ITEMS;
            while (sent < target)
            begin
                random_frame();
                if (round == 1 && !held && sent >= target - ROUND_ITEMS / 2)
                begin
                    drain();
                    held = 1'b1;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d input transfers and %0d frame results (%0d onsets, %0d ends)",
                 sent, sb.results, sb.onsets, sb.ends);
        $display("%0d frames dropped by reset or failure, %0d threshold settings",
                 sb.silent_frames, thr_writes);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: energy_gated_vad_onset_top.f
rtl/egvo_pkg.sv
rtl/egvo_unit.sv
rtl/egvo_seq.sv
rtl/energy_gated_vad_onset_top.sv
verif/tb_energy_gated_vad_onset_top.sv
